FILE: rtl/utf8_stream_decoder_core_assert.svh
`ifndef UTF8_STREAM_DECODER_CORE_ASSERT_SVH
`define UTF8_STREAM_DECODER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define UTF8D_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define UTF8D_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/utf8d_pkg.sv
package utf8d_pkg;

	localparam int BYTE_W          = 8;
	localparam int CP_W            = 21;
	localparam int LEN_W           = 3;
	localparam int SEEN_W          = 2;
	localparam int CHAR_IDX_W      = 16;
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int QUEUE_DEPTH     = 2;
	localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
	localparam int RAW_SLOTS       = 3;

	localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hC2;
	localparam logic [BYTE_W-1:0] LEAD2_HI = 8'hDF;
	localparam logic [BYTE_W-1:0] LEAD3_LO = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD3_HI = 8'hEF;
	localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD4_HI = 8'hF4;
	localparam logic [BYTE_W-1:0] LEAD_SURR = 8'hED;
	localparam logic [BYTE_W-1:0] CONT_LO  = 8'h80;
	localparam logic [BYTE_W-1:0] CONT_HI  = 8'hBF;
	localparam logic [BYTE_W-1:0] E0_LO    = 8'hA0;
	localparam logic [BYTE_W-1:0] ED_HI    = 8'h9F;
	localparam logic [BYTE_W-1:0] F0_LO    = 8'h90;
	localparam logic [BYTE_W-1:0] F4_HI    = 8'h8F;
	localparam logic [BYTE_W-1:0] PAY_MASK = 8'h3F;

	typedef struct packed {
		logic [LEN_W-1:0]                 n;
		logic [CP_W-1:0]                  first_cp;
		logic [LEN_W-1:0]                 first_len;
		logic                             first_wf;
		logic [RAW_SLOTS-1:0][BYTE_W-1:0] raw;
		logic                             eot;
	} job_t;

	typedef struct packed {
		logic avail;
		logic full;
	} q_status_t;

	function automatic logic [LEN_W-1:0] lead_len(input logic [BYTE_W-1:0] b);
		logic [LEN_W-1:0] len;
		len = '0;
		if (b >= LEAD2_LO && b <= LEAD2_HI) len = 3'd2;
		else if (b >= LEAD3_LO && b <= LEAD3_HI) len = 3'd3;
		else if (b >= LEAD4_LO && b <= LEAD4_HI) len = 3'd4;
		return len;
	endfunction

	function automatic logic [CP_W-1:0] lead_payload(input logic [BYTE_W-1:0] b,
		input logic [LEN_W-1:0] len);
		logic [CP_W-1:0] v;
		v = '0;
		unique case (len)
			3'd2:    v = CP_W'(b & 8'h1F);
			3'd3:    v = CP_W'(b & 8'h0F);
			3'd4:    v = CP_W'(b & 8'h07);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/utf8_stream_decoder_core.sv
// The job for a character word enters the job queue when the byte that completes it is taken,
// then leaves through the registered output stage. Throughput: one byte per cycle while the
// job queue is not full; a byte whose sequence fails releases up to four words, one at a time.
// Reset: arst_n clears decoder state, the job queue and the character count at once;
// bytes are taken from the first cycle after reset is released.
module utf8_stream_decoder_core
	import utf8d_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_ready,
	input  logic [BYTE_W-1:0]     text_byte,
	input  logic                  end_of_text,
	output logic                  char_valid,
	input  logic                  char_ready,
	output logic [CP_W-1:0]       code_point,
	output logic [LEN_W-1:0]      byte_count,
	output logic                  well_formed,
	output logic [CHAR_IDX_W-1:0] char_number,
	output logic                  last_of_run,
	output logic                  text_done
);

	logic      accept, push, pop;
	job_t      job, head;
	q_status_t q_stat;

	assign byte_ready = !q_stat.full;
	assign accept     = byte_valid && byte_ready;

	utf8d_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.push        (push),
		.job         (job)
	);

	utf8d_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (job),
		.pop    (pop),
		.head   (head),
		.status (q_stat)
	);

	utf8d_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.avail       (q_stat.avail),
		.pop         (pop),
		.char_valid  (char_valid),
		.char_ready  (char_ready),
		.code_point  (code_point),
		.byte_count  (byte_count),
		.well_formed (well_formed),
		.char_number (char_number),
		.last_of_run (last_of_run),
		.text_done   (text_done)
	);

endmodule

FILE: rtl/utf8d_front.sv
module utf8d_front
	import utf8d_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [BYTE_W-1:0] text_byte,
	input  logic              end_of_text,
	output logic              push,
	output job_t              job
);

	logic [BYTE_W-1:0] lead_q, lead_nxt;
	logic [LEN_W-1:0]  len_q, len_nxt;
	logic [SEEN_W-1:0] seen_q, seen_nxt;
	logic [CP_W-1:0]   pv_q, pv_nxt;
	logic [BYTE_W-1:0] held_q [2];
	logic              held_we;

	logic [BYTE_W-1:0] lo, hi;
	logic              in_rng;
	logic [LEN_W-1:0]  f_len;
	logic [CP_W-1:0]   pv_ext;
	logic              is_ascii;
	logic              opens;

	always_comb begin
		lo = CONT_LO;
		hi = CONT_HI;
		if (seen_q == '0) begin
			unique case (lead_q)
				LEAD3_LO:  lo = E0_LO;
				LEAD_SURR: hi = ED_HI;
				LEAD4_LO:  lo = F0_LO;
				LEAD4_HI:  hi = F4_HI;
				default: begin
				end
			endcase
		end
		in_rng   = (text_byte >= lo) && (text_byte <= hi);
		f_len    = lead_len(text_byte);
		is_ascii = ~text_byte[BYTE_W-1];
		opens    = (f_len != '0) && !end_of_text;
		pv_ext   = {pv_q[CP_W-7:0], text_byte[5:0] & PAY_MASK[5:0]};
	end

	always_comb begin
		push      = 1'b0;
		held_we   = 1'b0;
		lead_nxt  = lead_q;
		len_nxt   = len_q;
		seen_nxt  = seen_q;
		pv_nxt    = pv_q;
		job.n         = 3'd1;
		job.first_cp  = CP_W'(text_byte);
		job.first_len = 3'd1;
		job.first_wf  = 1'b0;
		job.raw[0]    = (seen_q != '0) ? held_q[0] : text_byte;
		job.raw[1]    = (seen_q > 2'd1) ? held_q[1] : text_byte;
		job.raw[2]    = text_byte;
		job.eot       = end_of_text;

		if (len_q == '0) begin
			if (is_ascii) begin
				push         = 1'b1;
				job.first_wf = 1'b1;
			end else if (opens) begin
				lead_nxt = text_byte;
				len_nxt  = f_len;
				seen_nxt = '0;
				pv_nxt   = lead_payload(text_byte, f_len);
			end else begin
				push = 1'b1;
			end
		end else if (in_rng) begin
			if ({1'b0, seen_q} + 3'd2 >= len_q) begin
				push          = 1'b1;
				job.first_cp  = pv_ext;
				job.first_len = len_q;
				job.first_wf  = 1'b1;
				len_nxt       = '0;
			end else if (end_of_text) begin
				push         = 1'b1;
				job.first_cp = CP_W'(lead_q);
				job.n        = 3'd2 + {1'b0, seen_q};
				len_nxt      = '0;
			end else begin
				held_we  = 1'b1;
				seen_nxt = seen_q + 2'd1;
				pv_nxt   = pv_ext;
			end
		end else begin
			push         = 1'b1;
			job.first_cp = CP_W'(lead_q);
			len_nxt      = '0;
			if (!is_ascii && opens) begin
				job.n    = 3'd1 + {1'b0, seen_q};
				lead_nxt = text_byte;
				len_nxt  = f_len;
				seen_nxt = '0;
				pv_nxt   = lead_payload(text_byte, f_len);
			end else begin
				job.n = 3'd2 + {1'b0, seen_q};
			end
		end

		if (end_of_text) len_nxt = '0;
		if (len_nxt == '0) begin
			lead_nxt = '0;
			seen_nxt = '0;
			pv_nxt   = '0;
		end
		push = push && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= '0;
			len_q  <= '0;
			seen_q <= '0;
			pv_q   <= '0;
		end else if (accept) begin
			lead_q <= lead_nxt;
			len_q  <= len_nxt;
			seen_q <= seen_nxt;
			pv_q   <= pv_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && held_we) begin
			held_q[seen_q[0]] <= text_byte;
		end
	end

endmodule

FILE: rtl/utf8d_queue.sv
module utf8d_queue
	import utf8d_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  job_t      wr_job,
	input  logic      pop,
	output job_t      head,
	output q_status_t status
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push, do_pop;

	always_comb begin
		status.avail = (cnt_q != '0);
		status.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
		head         = mem_q[rd_ptr_q];
		do_push      = push && !status.full;
		do_pop       = pop && status.avail;
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
			if (do_pop) rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= QCNT_W'(cnt_q + 1'b1);
				2'b01:   cnt_q <= QCNT_W'(cnt_q - 1'b1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/utf8d_back.sv
module utf8d_back
	import utf8d_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  job_t                  head,
	input  logic                  avail,
	output logic                  pop,
	output logic                  char_valid,
	input  logic                  char_ready,
	output logic [CP_W-1:0]       code_point,
	output logic [LEN_W-1:0]      byte_count,
	output logic                  well_formed,
	output logic [CHAR_IDX_W-1:0] char_number,
	output logic                  last_of_run,
	output logic                  text_done
);

	logic [1:0]             idx_q;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt_inc;
	logic                   emit, last;
	logic [CP_W-1:0]        e_cp;
	logic [LEN_W-1:0]       e_len;
	logic                   e_wf;
	logic [BYTE_W-1:0]      e_raw;

	always_comb begin
		emit    = avail && (!char_valid || char_ready);
		last    = ({1'b0, idx_q} + 3'd1) == head.n;
		pop     = emit && last;
		cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
		e_raw   = head.raw[idx_q - 2'd1];
		if (idx_q == '0) begin
			e_cp  = head.first_cp;
			e_len = head.first_len;
			e_wf  = head.first_wf;
		end else begin
			e_cp  = CP_W'(e_raw);
			e_len = 3'd1;
			e_wf  = ~e_raw[BYTE_W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid <= 1'b0;
			idx_q      <= '0;
			cnt_q      <= '0;
		end else begin
			if (emit) begin
				char_valid <= 1'b1;
				idx_q      <= last ? 2'd0 : idx_q + 2'd1;
				cnt_q      <= (last && head.eot) ? '0 : cnt_inc;
			end else if (char_ready) begin
				char_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			code_point  <= e_cp;
			byte_count  <= e_len;
			well_formed <= e_wf;
			char_number <= CHAR_IDX_W'(cnt_inc);
			last_of_run <= last;
			text_done   <= last && head.eot;
		end
	end

endmodule

FILE: rtl/utf8d_checker.sv
`include "utf8_stream_decoder_core_assert.svh"

module utf8d_checker
	import utf8d_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              char_valid,
	input logic              char_ready,
	input logic [CP_W-1:0]   code_point,
	input logic [LEN_W-1:0]  byte_count,
	input logic              well_formed,
	input logic              last_of_run,
	input logic              text_done
);

	`UTF8D_ASSERT_NEXT(a_hold, char_valid && !char_ready, char_valid && $stable(code_point) && $stable(byte_count), "stalled word changed")
	`UTF8D_ASSERT_NOW(a_done_last, char_valid && text_done, last_of_run, "text end not last of run")
	`UTF8D_ASSERT_NOW(a_len, char_valid, byte_count >= 3'd1 && byte_count <= 3'd4, "byte count out of range")
	`UTF8D_ASSERT_NOW(a_raw, char_valid && !well_formed, byte_count == 3'd1 && code_point < 21'h100, "bad raw fallback")

endmodule

bind utf8_stream_decoder_core utf8d_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.char_valid  (char_valid),
	.char_ready  (char_ready),
	.code_point  (code_point),
	.byte_count  (byte_count),
	.well_formed (well_formed),
	.last_of_run (last_of_run),
	.text_done   (text_done)
);

FILE: verif/utf8_stream_decoder_core_tb.sv
`timescale 1ns / 1ps

module utf8_stream_decoder_core_tb
	import utf8d_pkg::*;
();

	typedef struct {
		logic [BYTE_W-1:0] value;
		logic              eot;
	} byte_item_t;

	typedef struct {
		logic [CP_W-1:0]       cp;
		logic [LEN_W-1:0]      len;
		logic                  wf;
		logic [CHAR_IDX_W-1:0] idx;
		logic                  run_end;
		logic                  done;
	} char_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  byte_valid = 1'b0;
	logic                  byte_ready;
	logic [BYTE_W-1:0]     text_byte = '0;
	logic                  end_of_text = 1'b0;
	logic                  char_valid;
	logic                  char_ready = 1'b0;
	logic [CP_W-1:0]       code_point;
	logic [LEN_W-1:0]      byte_count;
	logic                  well_formed;
	logic [CHAR_IDX_W-1:0] char_number;
	logic                  last_of_run;
	logic                  text_done;

	byte_item_t pending_bytes[$];
	char_word_t expected_chars[$];
	char_word_t run_words[$];

	int bytes_offered = 0;
	int bytes_taken = 0;
	int mismatches = 0;
	int first_phase_end = 0;
	int second_phase_end = 0;
	int send_idle_pct;
	int recv_idle_pct;

	byte_item_t next_item;
	char_word_t got_word;
	char_word_t want_word;

	logic [BYTE_W-1:0]     dec_lead = '0;
	logic [LEN_W-1:0]      dec_len = '0;
	logic [SEEN_W-1:0]     dec_seen = '0;
	logic [CP_W-1:0]       dec_acc = '0;
	logic [BYTE_W-1:0]     dec_held [2];
	logic [CHAR_IDX_W-1:0] dec_chars = '0;

	utf8_stream_decoder_core #(
		.COUNT_WIDTH(COUNT_WIDTH_DEF)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.text_byte  (text_byte),
		.end_of_text(end_of_text),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.code_point (code_point),
		.byte_count (byte_count),
		.well_formed(well_formed),
		.char_number(char_number),
		.last_of_run(last_of_run),
		.text_done  (text_done)
	);

	always #4 clk = ~clk;

	function void add_word(input logic [CP_W-1:0] cp, input logic [LEN_W-1:0] len,
		input logic wf);
		char_word_t w;
		if (run_words.size() >= 4) return;
		if (dec_chars != '1) dec_chars = dec_chars + 1'b1;
		w.cp = cp;
		w.len = len;
		w.wf = wf;
		w.idx = dec_chars;
		w.run_end = 1'b0;
		w.done = 1'b0;
		run_words.push_back(w);
	endfunction

	function void close_sequence();
		dec_len = '0;
		dec_seen = '0;
		dec_acc = '0;
		dec_lead = '0;
	endfunction

	function void release_held();
		add_word(CP_W'(dec_lead), 3'd1, 1'b0);
		for (int i = 0; i < 2; i++)
			if (i < dec_seen) add_word(CP_W'(dec_held[i]), 3'd1, 1'b0);
	endfunction

	function void start_fresh(input logic [BYTE_W-1:0] b, input logic eot);
		logic [LEN_W-1:0] len;
		logic [CP_W-1:0]  val;
		len = '0;
		val = '0;
		if (b < CONT_LO) begin
			add_word(CP_W'(b), 3'd1, 1'b1);
			return;
		end
		if (b >= LEAD2_LO && b <= LEAD2_HI) begin
			len = 3'd2;
			val = CP_W'(b & 8'h1F);
		end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
			len = 3'd3;
			val = CP_W'(b & 8'h0F);
		end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
			len = 3'd4;
			val = CP_W'(b & 8'h07);
		end
		if (len == 0 || eot) begin
			add_word(CP_W'(b), 3'd1, 1'b0);
			return;
		end
		dec_lead = b;
		dec_len = len;
		dec_seen = '0;
		dec_acc = val;
	endfunction

	function void decode_byte(input logic [BYTE_W-1:0] b, input logic eot);
		logic [LEN_W-1:0]  pos;
		logic [BYTE_W-1:0] lo;
		logic [BYTE_W-1:0] hi;
		run_words.delete();
		if (dec_len == 0) begin
			start_fresh(b, eot);
		end else begin
			pos = LEN_W'(dec_seen) + 1'b1;
			lo = CONT_LO;
			hi = CONT_HI;
			if (pos == 1) begin
				if (dec_lead == LEAD3_LO) lo = E0_LO;
				else if (dec_lead == LEAD_SURR) hi = ED_HI;
				else if (dec_lead == LEAD4_LO) lo = F0_LO;
				else if (dec_lead == LEAD4_HI) hi = F4_HI;
			end
			if (b >= lo && b <= hi) begin
				dec_acc = {dec_acc[CP_W-7:0], b[5:0]};
				if (pos + 1'b1 >= dec_len) begin
					add_word(dec_acc, dec_len, 1'b1);
					close_sequence();
				end else if (eot) begin
					release_held();
					add_word(CP_W'(b), 3'd1, 1'b0);
					close_sequence();
				end else begin
					dec_held[dec_seen[0]] = b;
					dec_seen = dec_seen + 1'b1;
				end
			end else begin
				release_held();
				close_sequence();
				start_fresh(b, eot);
			end
		end
		if (run_words.size() > 0) begin
			run_words[run_words.size()-1].run_end = 1'b1;
			run_words[run_words.size()-1].done = eot;
		end
		if (eot) begin
			dec_chars = '0;
			close_sequence();
		end
		foreach (run_words[i]) expected_chars.push_back(run_words[i]);
	endfunction

	function void add_byte(input logic [BYTE_W-1:0] value, input logic eot);
		byte_item_t it;
		it.value = value;
		it.eot = eot;
		pending_bytes.push_back(it);
	endfunction

	function automatic logic [BYTE_W-1:0] pick(input logic [BYTE_W-1:0] lo,
		input logic [BYTE_W-1:0] hi);
		case ($urandom_range(3))
			0: return lo;
			1: return hi;
			default: return BYTE_W'($urandom_range(hi, lo));
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] pick_lead(input int len);
		case (len)
			2: return pick(LEAD2_LO, LEAD2_HI);
			3: return pick(LEAD3_LO, LEAD3_HI);
			default: return pick(LEAD4_LO, LEAD4_HI);
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] pick_second(input logic [BYTE_W-1:0] lead);
		if (lead == LEAD3_LO) return pick(E0_LO, CONT_HI);
		if (lead == LEAD_SURR) return pick(CONT_LO, ED_HI);
		if (lead == LEAD4_LO) return pick(F0_LO, CONT_HI);
		if (lead == LEAD4_HI) return pick(CONT_LO, F4_HI);
		return pick(CONT_LO, CONT_HI);
	endfunction

	function void add_good_char(input int len);
		logic [BYTE_W-1:0] lead;
		if (len == 1) begin
			add_byte(pick(8'h00, 8'h7F), 1'b0);
			return;
		end
		lead = pick_lead(len);
		add_byte(lead, 1'b0);
		add_byte(pick_second(lead), 1'b0);
		for (int i = 2; i < len; i++) add_byte(pick(CONT_LO, CONT_HI), 1'b0);
	endfunction

	function void add_broken_char();
		int                len;
		int                good;
		logic [BYTE_W-1:0] lead;
		logic [BYTE_W-1:0] bad;
		len = $urandom_range(4, 2);
		good = $urandom_range(len - 2);
		lead = pick_lead(len);
		add_byte(lead, 1'b0);
		for (int i = 0; i < good; i++)
			add_byte(i == 0 ? pick_second(lead) : pick(CONT_LO, CONT_HI), 1'b0);
		if ($urandom_range(1)) begin
			bad = BYTE_W'($urandom_range(255));
			if (bad >= CONT_LO && bad <= CONT_HI && $urandom_range(1)) bad = bad ^ 8'h40;
			add_byte(bad, 1'b0);
		end
	endfunction

	function void add_directed();
		add_byte(8'h00, 1'b0);
		add_byte(8'h7F, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'hC1, 1'b0);
		add_byte(8'hF5, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'hC2, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'hE0, 1'b0);
		add_byte(8'hA0, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'hF4, 1'b0);
		add_byte(8'h8F, 1'b0);
		add_byte(8'hBF, 1'b0);
		add_byte(8'hBF, 1'b0);
		add_byte(8'hF0, 1'b0);
		add_byte(8'h90, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'hE1, 1'b0);
		add_byte(8'hED, 1'b0);
		add_byte(8'hA0, 1'b0);
		add_byte(8'hC2, 1'b1);
		add_byte(8'hF1, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'h80, 1'b1);
	endfunction

	function void add_random_texts(input int target);
		int start;
		int chars;
		int sel;
		start = pending_bytes.size();
		while (pending_bytes.size() - start < target) begin
			chars = $urandom_range(12, 1);
			for (int c = 0; c < chars; c++) begin
				sel = $urandom_range(99);
				if (sel < 70) add_good_char($urandom_range(4, 1));
				else if (sel < 85) add_broken_char();
				else add_byte(pick(8'h00, 8'hFF), 1'b0);
			end
			pending_bytes[pending_bytes.size()-1].eot = 1'b1;
		end
	endfunction

	// sender and receiver idling by phase
	always @(negedge clk) begin
		if (arst_n) begin
			if (bytes_offered < first_phase_end) begin
				send_idle_pct = 17;
				recv_idle_pct = 50;
			end else if (bytes_offered < second_phase_end) begin
				send_idle_pct = 50;
				recv_idle_pct = 17;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (bytes_taken == bytes_offered) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_item = pending_bytes.pop_front();
					byte_valid <= 1'b1;
					text_byte <= next_item.value;
					end_of_text <= next_item.eot;
					bytes_offered <= bytes_offered + 1;
				end else begin
					byte_valid <= 1'b0;
				end
			end
			char_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && byte_ready) begin
				decode_byte(text_byte, end_of_text);
				bytes_taken <= bytes_taken + 1;
			end
			if (char_valid && char_ready) begin
				got_word.cp = code_point;
				got_word.len = byte_count;
				got_word.wf = well_formed;
				got_word.idx = char_number;
				got_word.run_end = last_of_run;
				got_word.done = text_done;
				if (expected_chars.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected char word: cp=%06h len=%0d wf=%0b idx=%0d last=%0b done=%0b",
							got_word.cp, got_word.len, got_word.wf, got_word.idx,
							got_word.run_end, got_word.done);
				end else begin
					want_word = expected_chars.pop_front();
					if (got_word.cp !== want_word.cp || got_word.len !== want_word.len ||
						got_word.wf !== want_word.wf || got_word.idx !== want_word.idx ||
						got_word.run_end !== want_word.run_end ||
						got_word.done !== want_word.done) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("char word mismatch at %0t", $realtime);
							$display("  expected cp=%06h len=%0d wf=%0b idx=%0d last=%0b done=%0b",
								want_word.cp, want_word.len, want_word.wf, want_word.idx,
								want_word.run_end, want_word.done);
							$display("  actual   cp=%06h len=%0d wf=%0b idx=%0d last=%0b done=%0b",
								got_word.cp, got_word.len, got_word.wf, got_word.idx,
								got_word.run_end, got_word.done);
						end
					end
				end
			end
		end
	end

	initial begin
		add_directed();
		add_random_texts(275);
		first_phase_end = pending_bytes.size() / 3;
		second_phase_end = 2 * pending_bytes.size() / 3;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (pending_bytes.size() != 0 || bytes_taken != bytes_offered) @(negedge clk);
		while (expected_chars.size() != 0) @(negedge clk);
		repeat (16) @(negedge clk);
		if (mismatches == 0 && expected_chars.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
